/* rtl/trlf_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trlf_pkg: shared constants and types for the triangle rotation fit
// Pipeline depths, fixed-point constants and sideband flag bundles.
// ----------------------------------------------------------------------------
package trlf_pkg;

  // Square root: one result bit per stage, 64-bit radicand, 32-bit root
  localparam int unsigned SQRT_STAGES = 32;
  // Divider: one quotient bit per stage, quotient never above 2^30
  localparam int unsigned DIV_STAGES  = 31;

  localparam logic [30:0] Q30_ONE    = 31'h4000_0000;
  localparam logic [15:0] THR_RESET  = 16'd1;
  localparam logic [31:0] THR_SQ_RST = 32'd1;

  // Per-triangle flags that ride along the pipeline
  typedef struct packed {
    logic last;
    logic sat;
    logic degen;
    logic na;
    logic nb;
  } trlf_flags_t;

  // Sideband during the norm square root
  typedef struct packed {
    trlf_flags_t f;
    logic [30:0] sa;
    logic [30:0] sb;
  } trlf_rt_side_t;

  // Sideband during the divide
  typedef struct packed {
    trlf_flags_t f;
    logic [23:0] q;
  } trlf_dv_side_t;

endpackage

/* rtl/trlf_isqrt.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trlf_isqrt: pipelined integer square root
// floor(sqrt(rad)) of a 64-bit value, one root bit per stage, advances on en.
// ----------------------------------------------------------------------------
module trlf_isqrt (
  input  logic        clk,
  input  logic        en,
  input  logic [63:0] rad,
  output logic [31:0] root
);
  import trlf_pkg::*;

  logic [35:0] rem_r  [1:SQRT_STAGES];
  logic [31:0] root_r [1:SQRT_STAGES];
  logic [63:0] nsh_r  [1:SQRT_STAGES];

  for (genvar s = 0; s < SQRT_STAGES; s++) begin : g_stage
    logic [35:0] rem_i;
    logic [31:0] root_i;
    logic [63:0] n_i;
    logic [35:0] cur;
    logic [35:0] trial;
    logic        ge;

    if (s == 0) begin : g_first
      assign rem_i  = '0;
      assign root_i = '0;
      assign n_i    = rad;
    end else begin : g_next
      assign rem_i  = rem_r[s];
      assign root_i = root_r[s];
      assign n_i    = nsh_r[s];
    end

    // bring down two radicand bits, try subtracting 4*root+1
    assign cur   = {rem_i[33:0], n_i[63:62]};
    assign trial = {2'b00, root_i, 2'b01};
    assign ge    = (cur >= trial);

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[s+1]  <= ge ? (cur - trial) : cur;
        root_r[s+1] <= {root_i[30:0], ge};
        nsh_r[s+1]  <= {n_i[61:0], 2'b00};
      end
    end
  end

  assign root = root_r[SQRT_STAGES];

endmodule

/* rtl/triangle_local_rotation_fit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// triangle_local_rotation_fit: per-triangle 2D rotation fit
// Jacobian from edges and inverse rest matrix, closest rotation, sqrt(area)
// scaled right-hand side entries.
//
//   channel | handshake             | contents
//   --------+-----------------------+---------------------------------------
//   tri     | tri_valid / tri_stall | vertices, inverse rest matrix, area
//   rot     | rot_valid / rot_stall | rotation, scaled entries, flags
//   cfg     | cfg_valid / cfg_ready | degenerate_threshold (16 bit)
//
// One triangle per cycle while not stalled; 6 Jacobian/norm stages, 32-stage
// square root, divider setup, 31-stage divider, multiply and output stages.
// Synchronous reset clears valid bits and sets the threshold to 1.
// A stall on a valid result freezes the whole pipeline; tri_stall follows.
// cfg_ready is always high.
// ----------------------------------------------------------------------------
module triangle_local_rotation_fit (
  input  logic               clk,
  input  logic               rst,
  input  logic               tri_valid,
  output logic               tri_stall,
  input  logic signed [31:0] p0_x,
  input  logic signed [31:0] p0_y,
  input  logic signed [31:0] p1_x,
  input  logic signed [31:0] p1_y,
  input  logic signed [31:0] p2_x,
  input  logic signed [31:0] p2_y,
  input  logic signed [31:0] inv_a,
  input  logic signed [31:0] inv_b,
  input  logic signed [31:0] inv_c,
  input  logic signed [31:0] inv_d,
  input  logic        [31:0] rest_area,
  input  logic               last_in,
  output logic               rot_valid,
  input  logic               rot_stall,
  output logic signed [31:0] rot_cos,
  output logic signed [31:0] rot_sin,
  output logic signed [33:0] scaled_cos,
  output logic signed [33:0] scaled_sin,
  output logic               degenerate,
  output logic               saturated,
  output logic               last_out,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic        [15:0] cfg_data
);
  import trlf_pkg::*;

  logic adv;

  // whole pipe moves unless the output register is full and held
  assign adv       = !(rot_valid && rot_stall);
  assign tri_stall = !adv;
  assign cfg_ready = 1'b1;

  // threshold register and its square
  logic [15:0] thr;
  logic [31:0] thr_sq;

  always_ff @(posedge clk) begin
    if (rst) begin
      thr    <= THR_RESET;
      thr_sq <= THR_SQ_RST;
    end else begin
      if (cfg_valid) begin
        thr <= cfg_data;
      end
      thr_sq <= thr * thr;
    end
  end

  // stage 1: edge differences
  logic               v1, last1;
  logic signed [32:0] m00, m10, m01, m11;
  logic signed [31:0] ia, ib, ic, id;
  logic        [31:0] area1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (adv) begin
      v1 <= tri_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      m00   <= 33'(p1_x) - 33'(p0_x);
      m10   <= 33'(p1_y) - 33'(p0_y);
      m01   <= 33'(p2_x) - 33'(p0_x);
      m11   <= 33'(p2_y) - 33'(p0_y);
      ia    <= inv_a;
      ib    <= inv_b;
      ic    <= inv_c;
      id    <= inv_d;
      area1 <= rest_area;
      last1 <= last_in;
    end
  end

  // stage 2: eight products, two per Jacobian entry
  logic               v2, last2;
  logic signed [64:0] prod [0:7];
  logic        [31:0] area2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (adv) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      prod[0] <= m00 * ia;
      prod[1] <= m01 * ic;
      prod[2] <= m00 * ib;
      prod[3] <= m01 * id;
      prod[4] <= m10 * ia;
      prod[5] <= m11 * ic;
      prod[6] <= m10 * ib;
      prod[7] <= m11 * id;
      area2   <= area1;
      last2   <= last1;
    end
  end

  // stage 3: pair sums, floor shift and saturate (J00, J01, J10, J11)
  logic signed [65:0] jsum [0:3];
  logic        [49:0] jsh  [0:3];
  logic        [3:0]  jovf;
  logic signed [31:0] jval [0:3];

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      jsum[k] = 66'(prod[2*k]) + 66'(prod[2*k+1]);
      jsh[k]  = jsum[k][65:16];
      jovf[k] = (jsh[k][49:31] != {19{jsh[k][49]}});
      if (jovf[k]) begin
        jval[k] = jsh[k][49] ? 32'sh8000_0000 : 32'sh7fff_ffff;
      end else begin
        jval[k] = jsh[k][31:0];
      end
    end
  end

  logic               v3, last3, sat3;
  logic signed [31:0] jm [0:3];
  logic        [31:0] area3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (adv) begin
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < 4; k++) begin
        jm[k] <= jval[k];
      end
      sat3  <= |jovf;
      area3 <= area2;
      last3 <= last2;
    end
  end

  // stage 4: rotation pair and magnitudes
  logic signed [32:0] pa, pb;
  assign pa = 33'(jm[0]) + 33'(jm[3]);
  assign pb = 33'(jm[1]) - 33'(jm[2]);

  logic        v4, last4, sat4, na4, nb4;
  logic [32:0] ua4, ub4;
  logic [31:0] area4;

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else if (adv) begin
      v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ua4   <= pa[32] ? 33'(-pa) : 33'(pa);
      ub4   <= pb[32] ? 33'(-pb) : 33'(pb);
      na4   <= pa[32];
      nb4   <= pb[32];
      sat4  <= sat3;
      area4 <= area3;
      last4 <= last3;
    end
  end

  // stage 5: range shift, squares, small-norm terms
  logic [30:0] sa_c, sb_c;

  always_comb begin
    if (ua4[32] || ub4[32]) begin
      sa_c = ua4[32:2];
      sb_c = ub4[32:2];
    end else if (ua4[31] || ub4[31]) begin
      sa_c = ua4[31:1];
      sb_c = ub4[31:1];
    end else begin
      sa_c = ua4[30:0];
      sb_c = ub4[30:0];
    end
  end

  logic        v5, last5, sat5, na5, nb5, lt_a5, lt_b5, zero5;
  logic [30:0] sa5, sb5;
  logic [61:0] sqa5, sqb5;
  logic [31:0] la5, lb5;
  logic [31:0] area5;

  always_ff @(posedge clk) begin
    if (rst) begin
      v5 <= 1'b0;
    end else if (adv) begin
      v5 <= v4;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sa5   <= sa_c;
      sb5   <= sb_c;
      sqa5  <= sa_c * sa_c;
      sqb5  <= sb_c * sb_c;
      la5   <= ua4[15:0] * ua4[15:0];
      lb5   <= ub4[15:0] * ub4[15:0];
      lt_a5 <= (ua4 < 33'(thr));
      lt_b5 <= (ub4 < 33'(thr));
      zero5 <= (ua4 == '0) && (ub4 == '0);
      na5   <= na4;
      nb5   <= nb4;
      sat5  <= sat4;
      area5 <= area4;
      last5 <= last4;
    end
  end

  // stage 6: radicand and degenerate decision
  logic          v6;
  logic [63:0]   rad6;
  logic [30:0]   sa6, sb6;
  logic [31:0]   area6;
  trlf_flags_t   fl6;

  always_ff @(posedge clk) begin
    if (rst) begin
      v6 <= 1'b0;
    end else if (adv) begin
      v6 <= v5;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      rad6      <= 64'(sqa5) + 64'(sqb5);
      fl6.degen <= zero5 ||
                   (lt_a5 && lt_b5 && ((33'(la5) + 33'(lb5)) < 33'(thr_sq)));
      fl6.na    <= na5;
      fl6.nb    <= nb5;
      fl6.sat   <= sat5;
      fl6.last  <= last5;
      sa6       <= sa5;
      sb6       <= sb5;
      area6     <= area5;
    end
  end

  // square roots: norm and area
  logic [31:0] root_r, root_q;

  trlf_isqrt u_root_norm (
    .clk  (clk),
    .en   (adv),
    .rad  (rad6),
    .root (root_r)
  );

  trlf_isqrt u_root_area (
    .clk  (clk),
    .en   (adv),
    .rad  ({16'd0, area6, 16'd0}),
    .root (root_q)
  );

  // sideband alongside the square roots
  trlf_rt_side_t rt_side [1:SQRT_STAGES];
  logic          rt_vld  [1:SQRT_STAGES];

  for (genvar g = 0; g < SQRT_STAGES; g++) begin : g_rt
    if (g == 0) begin : g_first
      always_ff @(posedge clk) begin
        if (rst) begin
          rt_vld[1] <= 1'b0;
        end else if (adv) begin
          rt_vld[1] <= v6;
        end
      end
      always_ff @(posedge clk) begin
        if (adv) begin
          rt_side[1] <= '{f: fl6, sa: sa6, sb: sb6};
        end
      end
    end else begin : g_next
      always_ff @(posedge clk) begin
        if (rst) begin
          rt_vld[g+1] <= 1'b0;
        end else if (adv) begin
          rt_vld[g+1] <= rt_vld[g];
        end
      end
      always_ff @(posedge clk) begin
        if (adv) begin
          rt_side[g+1] <= rt_side[g];
        end
      end
    end
  end

  // divider setup: rounded numerators, nonzero divisor
  logic [31:0] r_fix;
  assign r_fix = (root_r == '0) ? 32'd1 : root_r;

  logic          dv0;
  logic [31:0]   dr0;
  logic [61:0]   dnum [0:1];
  trlf_dv_side_t ds0;

  always_ff @(posedge clk) begin
    if (rst) begin
      dv0 <= 1'b0;
    end else if (adv) begin
      dv0 <= rt_vld[SQRT_STAGES];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dr0     <= r_fix;
      dnum[0] <= 62'({rt_side[SQRT_STAGES].sa, 30'd0}) + 62'(r_fix[31:1]);
      dnum[1] <= 62'({rt_side[SQRT_STAGES].sb, 30'd0}) + 62'(r_fix[31:1]);
      ds0     <= '{f: rt_side[SQRT_STAGES].f, q: root_q[23:0]};
    end
  end

  // restoring divider, one quotient bit per stage, two lanes (cos, sin)
  logic [31:0]   drem [0:1][1:DIV_STAGES];
  logic [30:0]   dnl  [0:1][1:DIV_STAGES];
  logic [30:0]   dquo [0:1][1:DIV_STAGES];
  logic [31:0]   dr   [1:DIV_STAGES];
  trlf_dv_side_t ds   [1:DIV_STAGES];
  logic          dvv  [1:DIV_STAGES];

  for (genvar j = 0; j < DIV_STAGES; j++) begin : g_div
    logic [31:0]   r_i;
    trlf_dv_side_t s_i;
    logic          v_i;

    if (j == 0) begin : g_first
      assign r_i = dr0;
      assign s_i = ds0;
      assign v_i = dv0;
    end else begin : g_next
      assign r_i = dr[j];
      assign s_i = ds[j];
      assign v_i = dvv[j];
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        dvv[j+1] <= 1'b0;
      end else if (adv) begin
        dvv[j+1] <= v_i;
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        dr[j+1] <= r_i;
        ds[j+1] <= s_i;
      end
    end

    for (genvar ln = 0; ln < 2; ln++) begin : g_lane
      logic [31:0] rem_i;
      logic [30:0] nl_i, quo_i;
      logic [32:0] cur, diff;
      logic        ge;

      if (j == 0) begin : g_first
        assign rem_i = 32'(dnum[ln][61:31]);
        assign nl_i  = dnum[ln][30:0];
        assign quo_i = '0;
      end else begin : g_next
        assign rem_i = drem[ln][j];
        assign nl_i  = dnl[ln][j];
        assign quo_i = dquo[ln][j];
      end

      assign cur  = {rem_i, nl_i[30]};
      assign diff = cur - {1'b0, r_i};
      assign ge   = (cur >= {1'b0, r_i});

      always_ff @(posedge clk) begin
        if (adv) begin
          drem[ln][j+1] <= ge ? diff[31:0] : cur[31:0];
          dnl[ln][j+1]  <= {nl_i[29:0], 1'b0};
          dquo[ln][j+1] <= {quo_i[29:0], ge};
        end
      end
    end
  end

  // clip, identity override, then area scaling multiply
  trlf_dv_side_t dsl;
  logic [30:0]   qc, qs, cm, sm;

  assign dsl = ds[DIV_STAGES];
  assign qc  = (dquo[0][DIV_STAGES] > Q30_ONE) ? Q30_ONE : dquo[0][DIV_STAGES];
  assign qs  = (dquo[1][DIV_STAGES] > Q30_ONE) ? Q30_ONE : dquo[1][DIV_STAGES];
  assign cm  = dsl.f.degen ? Q30_ONE : qc;
  assign sm  = dsl.f.degen ? 31'd0 : qs;

  logic        mv;
  logic [54:0] mpc, mps;
  logic [30:0] mcm, msm;
  trlf_flags_t mfl;

  always_ff @(posedge clk) begin
    if (rst) begin
      mv <= 1'b0;
    end else if (adv) begin
      mv <= dvv[DIV_STAGES];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      mpc <= dsl.q * cm;
      mps <= dsl.q * sm;
      mcm <= cm;
      msm <= sm;
      // identity carries no sign
      mfl <= '{last:  dsl.f.last,
               sat:   dsl.f.sat,
               degen: dsl.f.degen,
               na:    dsl.f.na && !dsl.f.degen,
               nb:    dsl.f.nb && !dsl.f.degen};
    end
  end

  // output register: round to nearest, apply signs
  logic [54:0] rc_sum, rs_sum;
  logic [24:0] scm, ssm;

  assign rc_sum = mpc + 55'h2000_0000;
  assign rs_sum = mps + 55'h2000_0000;
  assign scm    = rc_sum[54:30];
  assign ssm    = rs_sum[54:30];

  always_ff @(posedge clk) begin
    if (rst) begin
      rot_valid <= 1'b0;
    end else if (adv) begin
      rot_valid <= mv;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      rot_cos    <= mfl.na ? -32'(mcm) : 32'(mcm);
      rot_sin    <= mfl.nb ? -32'(msm) : 32'(msm);
      scaled_cos <= mfl.na ? -34'(scm) : 34'(scm);
      scaled_sin <= mfl.nb ? -34'(ssm) : 34'(ssm);
      degenerate <= mfl.degen;
      saturated  <= mfl.sat;
      last_out   <= mfl.last;
    end
  end

  // checks
  a_degen_identity: assert property (@(posedge clk) disable iff (rst)
    (rot_valid && degenerate) |->
      (rot_cos == 32'sh4000_0000 && rot_sin == 32'sd0 && scaled_sin == 34'sd0))
    else $error("degenerate result is not the identity");

  a_cos_range: assert property (@(posedge clk) disable iff (rst)
    rot_valid |-> (rot_cos <= 32'sh4000_0000 && rot_cos >= -32'sh4000_0000 &&
                   rot_sin <= 32'sh4000_0000 && rot_sin >= -32'sh4000_0000))
    else $error("rotation entry out of range");

  a_scaled_sign: assert property (@(posedge clk) disable iff (rst)
    rot_valid |-> ((scaled_cos == 34'sd0 || scaled_cos[33] == rot_cos[31]) &&
                   (scaled_sin == 34'sd0 || scaled_sin[33] == rot_sin[31])))
    else $error("scaled entry sign differs from rotation");

endmodule
